// File: hw/rtl/tfr_pkg.sv
package tfr_pkg;

  localparam int MaxColsDefault = 128;
  localparam int MaxRowsDefault = 64;

  localparam logic [2:0] FUNC_PLOT   = 3'd0;
  localparam logic [2:0] FUNC_FILL   = 3'd1;
  localparam logic [2:0] FUNC_CIRCLE = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [11:0] x_coord;
    logic signed [11:0] y_coord;
    logic [7:0]         extent_w;
    logic [7:0]         extent_h;
    logic [7:0]         radius;
    logic [15:0]        tile_char;
    logic [2:0]         tile_fore;
    logic [2:0]         tile_back;
  } req_t;

  typedef struct packed {
    logic [15:0] read_char;
    logic [2:0]  read_fore;
    logic [2:0]  read_back;
    logic        in_frame;
  } rsp_t;

  // Classified command handed from front to back.
  typedef enum logic [2:0] {
    OP_NONE = 3'b001,
    OP_RECT = 3'b010,
    OP_CIRC = 3'b100
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               is_read;
    logic signed [11:0] x0;
    logic signed [11:0] y0;
    logic [10:0]        w;
    logic [10:0]        h;
    logic [7:0]         radius;
    logic [21:0]        tile;
  } cmd_t;

endpackage

// File: hw/rtl/tfr_front.sv
module tfr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  output logic          stall_out,
  input  tfr_pkg::req_t req,
  input  logic [10:0]   eff_w,
  input  logic [10:0]   eff_h,
  output logic          q_valid,
  input  logic          q_stall,
  output tfr_pkg::cmd_t q_cmd
);
  import tfr_pkg::*;

  localparam int Depth = 2;

  cmd_t      mem [Depth];
  logic      wp, rp;
  logic [1:0] count;
  cmd_t      cls;
  logic      push, pop;

  always_comb begin
    cls = '0;
    cls.op = OP_NONE;
    cls.x0 = req.x_coord;
    cls.y0 = req.y_coord;
    cls.radius = req.radius;
    cls.tile = {req.tile_back, req.tile_fore, req.tile_char};
    cls.w = 11'd1;
    cls.h = 11'd1;
    unique case (req.func)
      FUNC_PLOT: cls.op = OP_RECT;
      FUNC_FILL: begin
        cls.op = OP_RECT;
        cls.w = {3'b0, req.extent_w};
        cls.h = {3'b0, req.extent_h};
      end
      FUNC_CIRCLE: cls.op = OP_CIRC;
      FUNC_CLEAR: begin
        cls.op = OP_RECT;
        cls.x0 = '0;
        cls.y0 = '0;
        cls.w = eff_w;
        cls.h = eff_h;
      end
      FUNC_READ: cls.is_read = 1'b1;
      default: cls.op = OP_NONE;
    endcase
  end

  assign stall_out = (count == 2'(Depth));
  assign push = valid_in && !stall_out;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && !q_stall;
  assign q_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cls;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= 2'(Depth))
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_push: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(Depth) && !pop) |=> count == 2'(Depth))
    else $error("queue lost entry");
endmodule

// File: hw/rtl/tfr_sqrt.sv
module tfr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] n,
  output logic        done,
  output logic [7:0]  root
);
  // Digit-by-digit root, one result bit per cycle.
  logic [7:0]  q;
  logic [3:0]  idx;
  logic        busy;

  // Restoring method over a shifting radicand.
  logic [15:0] src;
  logic [17:0] acc;
  logic [17:0] acc_next;
  logic        ge;

  always_comb begin
    acc_next = {acc[15:0], src[15:14]};
    ge = acc_next >= {8'b0, q, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx <= 4'd0;
      end else if (busy) begin
        idx <= idx + 4'd1;
        if (idx == 4'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      src <= n;
      acc <= '0;
      q <= '0;
    end else if (busy) begin
      src <= {src[13:0], 2'b00};
      if (ge) begin
        acc <= acc_next - {8'b0, q, 2'b01};
        q <= {q[6:0], 1'b1};
      end else begin
        acc <= acc_next;
        q <= {q[6:0], 1'b0};
      end
    end
  end

  assign root = q;
endmodule

// File: hw/rtl/tfr_back.sv
module tfr_back #(
  parameter int MaxCols = tfr_pkg::MaxColsDefault,
  parameter int MaxRows = tfr_pkg::MaxRowsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_stall,
  input  tfr_pkg::cmd_t q_cmd,
  input  logic [10:0]   eff_w,
  input  logic [10:0]   eff_h,
  output logic          valid,
  input  logic          stall,
  output tfr_pkg::rsp_t rsp,
  output logic          busy_clear
);
  import tfr_pkg::*;

  localparam int Cells = MaxCols * MaxRows;
  localparam int AW = $clog2(Cells);

  typedef enum logic [7:0] {
    S_CLR   = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RECT  = 8'b00000100,
    S_SQ    = 8'b00001000,
    S_SQW   = 8'b00010000,
    S_PUT   = 8'b00100000,
    S_RD    = 8'b01000000,
    S_OUT   = 8'b10000000
  } st_t;

  st_t state;
  logic [21:0] mem [Cells];
  logic [21:0] rdata;
  cmd_t cmd;
  logic [10:0] ci, cj;
  logic [8:0]  k;
  logic        pass2;
  logic [1:0]  quad;
  logic [7:0]  m;
  logic [AW-1:0] clr_addr;
  logic        rd_in;

  // point under test
  logic signed [13:0] px, py;
  logic signed [13:0] dx, dy;
  logic        pt_in_frame;
  logic [AW-1:0] addr;
  logic [21:0] prod;
  logic        we;
  logic [21:0] wdata;
  logic [AW-1:0] waddr;

  logic        sq_start, sq_done;
  logic [15:0] sq_n;
  logic [7:0]  sq_root;
  logic [15:0] r2, k2;

  always_comb begin
    r2 = 16'(cmd.radius) * 16'(cmd.radius);
    k2 = 16'(k[7:0]) * 16'(k[7:0]);
  end
  assign sq_n = r2 - k2;

  tfr_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .n(sq_n), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    dx = pass2 ? 14'(m) : 14'(k);
    dy = pass2 ? 14'(k) : 14'(m);
    px = 14'(cmd.x0);
    py = 14'(cmd.y0);
    if (state == S_RECT) begin
      px = 14'(cmd.x0) + 14'(ci);
      py = 14'(cmd.y0) + 14'(cj);
    end else if (state == S_PUT) begin
      case (quad)
        2'd0: begin px = px + dx; py = py + dy; end
        2'd1: begin px = px - dx; py = py + dy; end
        2'd2: begin px = px - dx; py = py - dy; end
        default: begin px = px + dx; py = py - dy; end
      endcase
    end
    pt_in_frame = !px[13] && !py[13] && (px < 14'(eff_w)) && (py < 14'(eff_h));
    prod = 22'(py[10:0]) * 22'(eff_w);
    addr = AW'(prod + 22'(px[10:0]));
  end

  assign q_stall = (state != S_IDLE);
  assign busy_clear = (state == S_CLR);
  assign sq_start = (state == S_SQ);

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = cmd.tile;
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if ((state == S_RECT && ci < cmd.w && cj < cmd.h) || state == S_PUT) begin
      we = pt_in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(Cells - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          ci <= '0;
          cj <= '0;
          k <= '0;
          pass2 <= 1'b0;
          quad <= '0;
          unique case (q_cmd.op)
            OP_RECT: state <= S_RECT;
            OP_CIRC: state <= S_SQ;
            default: state <= S_RD;
          endcase
        end
        S_RECT: begin
          if (ci + 11'd1 >= cmd.w || cmd.w == 11'd0) begin
            ci <= '0;
            cj <= cj + 11'd1;
            if (cj + 11'd1 >= cmd.h || cmd.h == 11'd0 || cmd.w == 11'd0) state <= S_OUT;
          end else begin
            ci <= ci + 11'd1;
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: if (sq_done) begin
          m <= sq_root;
          state <= S_PUT;
        end
        S_PUT: begin
          quad <= quad + 2'd1;
          if (quad == 2'd3) begin
            if (k[7:0] == cmd.radius) begin
              k <= '0;
              if (pass2) state <= S_OUT;
              else begin
                pass2 <= 1'b1;
                state <= S_SQ;
              end
            end else begin
              k <= k + 9'd1;
              state <= S_SQ;
            end
          end
        end
        S_RD: begin
          rd_in <= pt_in_frame;
          state <= S_OUT;
        end
        S_OUT: if (!valid || !stall) begin
          valid <= 1'b1;
          rsp.in_frame <= cmd.is_read && rd_in;
          {rsp.read_back, rsp.read_fore, rsp.read_char} <=
            (cmd.is_read && rd_in) ? rdata : 22'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (valid && !stall && state != S_OUT) valid <= 1'b0;
      if (state == S_IDLE && q_valid) rd_in <= 1'b0;
    end
  end

  a_out: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> valid)
    else $error("result dropped");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !valid)
    else $error("result during clear");
  a_q: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_valid) |=> state != S_IDLE)
    else $error("command not taken");
endmodule

// File: hw/rtl/tile_framebuffer_rasterizer_unit.sv
// Character-cell frame store with plot, rectangle fill, clear, circle
// outline and cell read-back.
// Input channel: valid/stall carrying req_t; one command per request.
// Output channel: valid/stall carrying rsp_t; exactly one response per
// request, in order. Non-read commands answer with all zeros.
// Config: cfg_we/cfg_index/cfg_data; index 0 frame_width, 1 frame_height.
// Drawing: fill and clear write one cell a cycle; circle runs 2*(r+1)
// steps of k, each of which waits on the serial square root before
// plotting its points.
// A two-entry queue sits between the command front and the draw engine,
// so a new request is taken while the engine works.
// Reset: frame size returns to 128x64; all MaxCols*MaxRows cells of the
// store are swept to zero, during which no request is drawn.
// When the receiver stalls, the response holds and the engine waits.
module tile_framebuffer_rasterizer_unit #(
  parameter int MaxCols = tfr_pkg::MaxColsDefault,
  parameter int MaxRows = tfr_pkg::MaxRowsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tfr_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output tfr_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data
);
  import tfr_pkg::*;

  logic [7:0]  frame_width;
  logic [6:0]  frame_height;
  logic [10:0] eff_w, eff_h;
  logic        q_valid, q_stall, busy_clear;
  cmd_t        q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 8'd128;
      frame_height <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_WIDTH) frame_width <= cfg_data;
      else frame_height <= cfg_data[6:0];
    end
  end

  // clamp frame to store
  assign eff_w = (32'(frame_width) > MaxCols) ? 11'(MaxCols) : 11'(frame_width);
  assign eff_h = (32'(frame_height) > MaxRows) ? 11'(MaxRows) : 11'(frame_height);

  tfr_front u_front (
    .clk(clk), .rst(rst), .valid_in(in_valid), .stall_out(in_stall), .req(in_req),
    .eff_w(eff_w), .eff_h(eff_h), .q_valid(q_valid), .q_stall(q_stall), .q_cmd(q_cmd)
  );

  tfr_back #(.MaxCols(MaxCols), .MaxRows(MaxRows)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_stall(q_stall), .q_cmd(q_cmd),
    .eff_w(eff_w), .eff_h(eff_h), .valid(out_valid), .stall(out_stall), .rsp(out_rsp),
    .busy_clear(busy_clear)
  );

  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("response out of reset");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !out_valid)
    else $error("response during sweep");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_rsp))
    else $error("response changed under stall");
endmodule
